// ===== rtl/rttq_pkg.sv =====
package rttq_pkg;

   // node indexes are 6 bits wide, so the table depth follows from that width
   localparam int ID_W      = 6;
   localparam int NODES     = 1 << ID_W;
   localparam int PAR_W     = ID_W + 1;
   localparam int DEPTH_W   = 6;
   localparam int STEP_W    = $clog2(NODES + 1);
   localparam int DEPTH_MAX = 63;
   localparam int CHILD_CAP = (NODES - 1 < 63) ? NODES - 1 : 63;

   localparam logic             CMD_ADD     = 1'b0;
   localparam logic             CMD_QUERY   = 1'b1;
   localparam logic             RSP_HEADER  = 1'b0;
   localparam logic             RSP_CHILD   = 1'b1;
   localparam logic [PAR_W-1:0] PARENT_NONE = {PAR_W{1'b1}};

   // halves of the link memory: first-child entries low, next-sibling entries high
   localparam logic             LINK_FC     = 1'b0;
   localparam logic             LINK_NS     = 1'b1;

   typedef logic [ID_W-1:0] node_type;

   typedef enum logic [1:0] {
      NK_ROOT     = 2'd0,
      NK_INTERNAL = 2'd1,
      NK_LEAF     = 2'd2
   } node_kind_type;

   typedef struct packed {
      logic     en;
      node_type parent;
      node_type child;
      logic     first;
   } add_req_type;

   typedef struct packed {
      logic     par_re;
      node_type par_addr;
      logic     fc_re;
      node_type fc_addr;
      logic     ns_re;
      node_type ns_addr;
   } read_req_type;

   typedef struct packed {
      node_type par_idx;
      node_type fc_idx;
      node_type ns_idx;
   } read_data_type;

endpackage

// ===== rtl/rttq_ram.sv =====
module rttq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/rttq_store.sv =====
module rttq_store import rttq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  add_req_type   add_req,
   input  read_req_type  rd_req,
   output read_data_type rd_data,
   output logic [NODES-1:0] par_valid,
   output logic [NODES-1:0] fc_valid,
   output logic [NODES-1:0] ns_valid
);

   logic [NODES-1:0] par_valid_ff, par_valid_in;
   logic [NODES-1:0] fc_valid_ff,  fc_valid_in;
   logic [NODES-1:0] ns_valid_ff,  ns_valid_in;
   logic             prev_ok_ff,   prev_ok_in;
   node_type         prev_idx_ff,  prev_idx_in;
   logic             fc_we;
   logic             ns_we;
   logic             link_we;
   logic [ID_W:0]    link_waddr;
   logic             link_re;
   logic [ID_W:0]    link_raddr;
   node_type         link_rdata;

   // a first child restarts the sibling chain, so no sibling link on it
   assign fc_we = add_req.en && add_req.first;
   assign ns_we = add_req.en && !add_req.first && prev_ok_ff;

   always_comb begin
      par_valid_in = par_valid_ff;
      fc_valid_in  = fc_valid_ff;
      ns_valid_in  = ns_valid_ff;
      prev_ok_in   = prev_ok_ff;
      prev_idx_in  = prev_idx_ff;
      if (add_req.en) begin
         par_valid_in[add_req.child] = 1'b1;
         prev_ok_in                  = 1'b1;
         prev_idx_in                 = add_req.child;
      end
      if (fc_we) begin
         fc_valid_in[add_req.parent] = 1'b1;
      end
      if (ns_we) begin
         ns_valid_in[prev_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         par_valid_ff <= '0;
         fc_valid_ff  <= '0;
         ns_valid_ff  <= '0;
         prev_ok_ff   <= 1'b0;
         prev_idx_ff  <= '0;
      end else begin
         par_valid_ff <= par_valid_in;
         fc_valid_ff  <= fc_valid_in;
         ns_valid_ff  <= ns_valid_in;
         prev_ok_ff   <= prev_ok_in;
         prev_idx_ff  <= prev_idx_in;
      end
   end

   rttq_ram #(.WIDTH(ID_W), .DEPTH(NODES)) u_par_ram (
      .clock (clock),
      .we    (add_req.en),
      .waddr (add_req.child),
      .wdata (add_req.parent),
      .re    (rd_req.par_re),
      .raddr (rd_req.par_addr),
      .rdata (rd_data.par_idx)
   );

   // first-child and next-sibling writes never coincide, and neither do their
   // reads (head on query accept, siblings while listing), so share one memory
   assign link_we    = fc_we || ns_we;
   assign link_waddr = fc_we ? {LINK_FC, add_req.parent} : {LINK_NS, prev_idx_ff};
   assign link_re    = rd_req.fc_re || rd_req.ns_re;
   assign link_raddr = rd_req.fc_re ? {LINK_FC, rd_req.fc_addr} : {LINK_NS, rd_req.ns_addr};

   rttq_ram #(.WIDTH(ID_W), .DEPTH(2 * NODES)) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (add_req.child),
      .re    (link_re),
      .raddr (link_raddr),
      .rdata (link_rdata)
   );

   assign rd_data.fc_idx = link_rdata;
   assign rd_data.ns_idx = link_rdata;

   assign par_valid = par_valid_ff;
   assign fc_valid  = fc_valid_ff;
   assign ns_valid  = ns_valid_ff;

endmodule

// ===== rtl/rooted_tree_table_query.sv =====
// Add beat: written to the tables at the accept edge; no result.
// Query beat: the header leaves once the parent walk ends (D = parent links
// walked, up to 64, one parent-table read per cycle), then one child beat per cycle,
// while the result side accepts, in sibling order (C children, one next-sibling read
// each, up to 63); the next request beat is taken only after the query's last beat.
// Reset is synchronous: it clears the table valid bits and the previous-child
// mark at once; no clearing pass, the block takes a beat on the next cycle.
module rooted_tree_table_query import rttq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [5:0] parent_id, [11:6] child_id, [12] first_child
   input  logic        req_tuser,   // [0] command
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [5:0] node_index, [12:6] parent_of_node,
                                    // [18:13] depth, [20:19] node_kind, [26:21] child_index
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LOOK = 5'b00010,
      ST_WALK = 5'b00100,
      ST_HEAD = 5'b01000,
      ST_LIST = 5'b10000
   } state_type;

   state_type           state_ff,   state_in;
   node_type            node_ff,    node_in;
   logic [STEP_W-1:0]   steps_ff,   steps_in;
   logic [DEPTH_W-1:0]  depth_ff,   depth_in;
   logic [PAR_W-1:0]    parent_ff,  parent_in;
   node_kind_type       nk_ff,      nk_in;
   node_type            fc_idx_ff,  fc_idx_in;
   node_type            cur_ff,     cur_in;
   logic                cur_ram_ff, cur_ram_in;
   logic [DEPTH_W-1:0]  cnt_ff,     cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_user_ff,  rsp_user_in;
   logic                rsp_last_ff,  rsp_last_in;
   logic [31:0]         rsp_data_ff,  rsp_data_in;

   add_req_type         add_req;
   read_req_type        rd_req;
   read_data_type       rd_data;
   logic [NODES-1:0]    par_valid;
   logic [NODES-1:0]    fc_valid;
   logic [NODES-1:0]    ns_valid;

   logic                accept;
   logic                out_free;
   node_type            req_parent;
   node_type            req_child;
   logic                req_first;
   logic [STEP_W-1:0]   step_base;
   logic [DEPTH_W-1:0]  dep_base;
   logic [STEP_W-1:0]   step_next;
   logic [DEPTH_W-1:0]  dep_next;
   logic                walk_on;
   node_type            list_cur;
   logic                list_more;

   assign req_parent = req_tdata[5:0];
   assign req_child  = req_tdata[11:6];
   assign req_first  = req_tdata[12];

   // one beat at a time: take a request only with no query in flight
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign add_req.en     = accept && (req_tuser == CMD_ADD);
   assign add_req.parent = req_parent;
   assign add_req.child  = req_child;
   assign add_req.first  = req_first;

   // one upward step of the walk: the parent read issued last cycle is in
   // rd_data.par_idx; count it and chase it if that node has a parent too and the step limit allows
   assign step_base = (state_ff == ST_LOOK) ? '0 : steps_ff;
   assign dep_base  = (state_ff == ST_LOOK) ? '0 : depth_ff;
   assign step_next = step_base + STEP_W'(1);
   assign dep_next  = (dep_base < DEPTH_W'(DEPTH_MAX)) ? dep_base + DEPTH_W'(1) : dep_base;
   assign walk_on   = (step_next < STEP_W'(NODES)) && par_valid[rd_data.par_idx];

   // the first child comes from the head register, later ones straight off
   // the sibling read port, which holds its data while the result side stalls
   assign list_cur  = cur_ram_ff ? rd_data.ns_idx : cur_ff;
   assign list_more = ns_valid[list_cur] && (cnt_ff < DEPTH_W'(CHILD_CAP));

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      steps_in     = steps_ff;
      depth_in     = depth_ff;
      parent_in    = parent_ff;
      nk_in        = nk_ff;
      fc_idx_in    = fc_idx_ff;
      cur_in       = cur_ff;
      cur_ram_in   = cur_ram_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;
      rd_req       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_tuser == CMD_QUERY)) begin
               rd_req.par_re   = 1'b1;
               rd_req.par_addr = req_parent;
               rd_req.fc_re    = 1'b1;
               rd_req.fc_addr  = req_parent;
               node_in         = req_parent;
               state_in        = ST_LOOK;
            end
         end
         ST_LOOK: begin
            // capture the node's own entries, then take the first step if any
            fc_idx_in = rd_data.fc_idx;
            if (par_valid[node_ff]) begin
               parent_in = {1'b0, rd_data.par_idx};
               nk_in     = fc_valid[node_ff] ? NK_INTERNAL : NK_LEAF;
               steps_in  = step_next;
               depth_in  = dep_next;
               if (walk_on) begin
                  rd_req.par_re   = 1'b1;
                  rd_req.par_addr = rd_data.par_idx;
                  state_in        = ST_WALK;
               end else begin
                  state_in = ST_HEAD;
               end
            end else begin
               parent_in = PARENT_NONE;
               nk_in     = NK_ROOT;
               steps_in  = '0;
               depth_in  = '0;
               state_in  = ST_HEAD;
            end
         end
         ST_WALK: begin
            steps_in = step_next;
            depth_in = dep_next;
            if (walk_on) begin
               rd_req.par_re   = 1'b1;
               rd_req.par_addr = rd_data.par_idx;
            end else begin
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = RSP_HEADER;
               rsp_last_in  = !fc_valid[node_ff];
               rsp_data_in  = {5'b0, node_type'(0), 2'(nk_ff), depth_ff, parent_ff, node_ff};
               if (fc_valid[node_ff]) begin
                  cur_in     = fc_idx_ff;
                  cur_ram_in = 1'b0;
                  cnt_in     = DEPTH_W'(1);
                  state_in   = ST_LIST;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LIST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = RSP_CHILD;
               rsp_last_in  = !list_more;
               rsp_data_in  = {5'b0, list_cur, 2'(nk_ff), depth_ff, parent_ff, node_ff};
               if (list_more) begin
                  rd_req.ns_re   = 1'b1;
                  rd_req.ns_addr = list_cur;
                  cur_ram_in     = 1'b1;
                  cnt_in         = cnt_ff + DEPTH_W'(1);
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_ram_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ram_ff   <= cur_ram_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      steps_ff    <= steps_in;
      depth_ff    <= depth_in;
      parent_ff   <= parent_in;
      nk_ff       <= nk_in;
      fc_idx_ff   <= fc_idx_in;
      cur_ff      <= cur_in;
      cnt_ff      <= cnt_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   rttq_store u_store (
      .clock     (clock),
      .reset     (reset),
      .add_req   (add_req),
      .rd_req    (rd_req),
      .rd_data   (rd_data),
      .par_valid (par_valid),
      .fc_valid  (fc_valid),
      .ns_valid  (ns_valid)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
